FILE: rtl/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

    // Result event codes
    localparam logic [1:0] EV_CHAR = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_BAD  = 2'd2;

    // Token kinds
    localparam logic [1:0] KIND_IDENT = 2'd0;
    localparam logic [1:0] KIND_NUM   = 2'd1;
    localparam logic [1:0] KIND_STR   = 2'd2;
    localparam logic [1:0] KIND_OP    = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Most results one input byte can give
    localparam int unsigned MAX_RES = 3;

    // One result item
    typedef struct packed {
        logic [1:0] event_res;
        logic [1:0] token_kind;
        logic [7:0] out_byte;
    } result_t;

    // Work handed from front to back: a burst of one to three results
    typedef struct packed {
        logic [1:0]                 cnt;
        result_t [MAX_RES-1:0]      res;
    } cmd_t;

    function automatic result_t mk_res(input logic [1:0] ev, input logic [1:0] kind,
                                       input logic [7:0] b);
        result_t r;
        r.event_res  = ev;
        r.token_kind = kind;
        r.out_byte   = b;
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_op(input logic [7:0] b);
        return b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH
            || b == CH_EQUAL;
    endfunction

endpackage

FILE: rtl/stt_front.sv
`timescale 1ns / 1ps

module stt_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    input  logic           in_eot,
    output logic           in_ready,
    input  logic           q_full,
    output logic           push,
    output stt_pkg::cmd_t  push_cmd
);
    import stt_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE  = 6'b000001,
        MODE_IDENT = 6'b000010,
        MODE_INT   = 6'b000100,
        MODE_DOT   = 6'b001000,
        MODE_FRAC  = 6'b010000,
        MODE_STR   = 6'b100000
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic       dq_reg, dq_next;
    logic [1:0] slot;
    logic       handled;
    logic       accept;
    logic [7:0] delim;
    cmd_t       cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && (cmd.cnt != 2'd0);
    assign push_cmd = cmd;
    assign delim    = dq_reg ? CH_DQUOTE : CH_SQUOTE;

    // Classify the byte against the open token and build the result burst
    always_comb
    begin
        mode_next = mode_reg;
        dq_next   = dq_reg;
        slot      = 2'd0;
        handled   = 1'b0;
        cmd       = '0;
        if (in_eot)
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    cmd.res[0] = mk_res(EV_END, KIND_IDENT, CH_NUL);
                    slot = 2'd1;
                end
                MODE_INT, MODE_DOT, MODE_FRAC:
                begin
                    cmd.res[0] = mk_res(EV_END, KIND_NUM, CH_NUL);
                    slot = 2'd1;
                end
                MODE_STR:
                begin
                    cmd.res[0] = mk_res(EV_END, KIND_STR, CH_NUL);
                    slot = 2'd1;
                end
                default:
                begin
                    slot = 2'd0;
                end
            endcase
            mode_next = MODE_IDLE;
        end
        else
        begin
            // continue or close the open token
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_letter(in_byte) || is_digit(in_byte))
                    begin
                        cmd.res[0] = mk_res(EV_CHAR, KIND_IDENT, in_byte);
                        slot = 2'd1;
                        handled = 1'b1;
                    end
                    else
                    begin
                        cmd.res[0] = mk_res(EV_END, KIND_IDENT, CH_NUL);
                        slot = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_INT:
                begin
                    if (is_digit(in_byte))
                    begin
                        cmd.res[0] = mk_res(EV_CHAR, KIND_NUM, in_byte);
                        slot = 2'd1;
                        handled = 1'b1;
                    end
                    else if (in_byte == CH_POINT)
                    begin
                        cmd.res[0] = mk_res(EV_CHAR, KIND_NUM, in_byte);
                        slot = 2'd1;
                        handled = 1'b1;
                        mode_next = MODE_DOT;
                    end
                    else
                    begin
                        cmd.res[0] = mk_res(EV_END, KIND_NUM, CH_NUL);
                        slot = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_DOT, MODE_FRAC:
                begin
                    if (is_digit(in_byte))
                    begin
                        cmd.res[0] = mk_res(EV_CHAR, KIND_NUM, in_byte);
                        slot = 2'd1;
                        handled = 1'b1;
                        mode_next = MODE_FRAC;
                    end
                    else
                    begin
                        cmd.res[0] = mk_res(EV_END, KIND_NUM, CH_NUL);
                        slot = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_STR:
                begin
                    if (in_byte == CH_NUL || in_byte == delim)
                    begin
                        cmd.res[0] = mk_res(EV_END, KIND_STR, CH_NUL);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        cmd.res[0] = mk_res(EV_CHAR, KIND_STR, in_byte);
                    end
                    slot = 2'd1;
                    handled = 1'b1;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            // start a new token from idle
            if (!handled && in_byte != CH_NUL && !is_space(in_byte))
            begin
                if (is_letter(in_byte))
                begin
                    cmd.res[slot] = mk_res(EV_CHAR, KIND_IDENT, in_byte);
                    slot = slot + 2'd1;
                    mode_next = MODE_IDENT;
                end
                else if (is_digit(in_byte))
                begin
                    cmd.res[slot] = mk_res(EV_CHAR, KIND_NUM, in_byte);
                    slot = slot + 2'd1;
                    mode_next = MODE_INT;
                end
                else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE)
                begin
                    dq_next = (in_byte == CH_DQUOTE);
                    mode_next = MODE_STR;
                end
                else if (is_op(in_byte))
                begin
                    cmd.res[slot] = mk_res(EV_CHAR, KIND_OP, in_byte);
                    slot = slot + 2'd1;
                    cmd.res[slot] = mk_res(EV_END, KIND_OP, CH_NUL);
                    slot = slot + 2'd1;
                end
                else
                begin
                    cmd.res[slot] = mk_res(EV_BAD, KIND_IDENT, in_byte);
                    slot = slot + 2'd1;
                end
            end
        end
        cmd.cnt = slot;
    end

    // Lexer state advances on every accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            dq_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            dq_reg   <= dq_next;
        end
    end

endmodule

FILE: rtl/stt_fifo.sv
`timescale 1ns / 1ps

module stt_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  stt_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output stt_pkg::cmd_t  head,
    output logic           empty
);
    import stt_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    cmd_t          store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = store_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/stt_back.sv
`timescale 1ns / 1ps

module stt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  stt_pkg::cmd_t  head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output stt_pkg::result_t out_res,
    output logic           out_last
);
    import stt_pkg::*;

    result_t    res_reg;
    logic       last_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       load;
    logic       take;
    logic       at_end;

    assign load      = !valid_reg || out_ready;
    assign take      = load && !empty;
    assign at_end    = (idx_reg == head.cnt - 2'd1);
    assign pop       = take && at_end;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

    // Walk the burst at the queue head, one result per cycle while the output is not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg  <= head.res[idx_reg];
            last_reg <= at_end;
        end
    end

endmodule

FILE: rtl/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Path: a byte's results are written into the burst queue, then into the output register.
// Throughput: one byte per cycle in unless the queue is full; one result per cycle out
// unless stalled by m_axis_tready; the burst queue absorbs bursts of several results.
// Reset: rst_n is asynchronous, active low; the lexer returns to between tokens,
// the queue empties and the output goes invalid.

module source_text_tokenizer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [3:0]  m_axis_tuser,   // [1:0] event_res, [3:2] token_kind
    output logic        m_axis_tlast    // last_result
);
    import stt_pkg::*;

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    cmd_t    q_in;
    cmd_t    q_head;
    result_t res;

    // Front: lexer state and classification
    stt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_eot   (s_axis_tlast),
        .in_ready (s_axis_tready),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_in)
    );

    // Burst queue between front and back
    stt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // Back: serialise bursts onto the output stream
    stt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = res.out_byte;
    assign m_axis_tuser = {res.token_kind, res.event_res};

endmodule
